// File: hw/rtl/gsi_pkg.sv
// gsi_pkg: shared types and constants of the weighted Gini split impurity block.
// No dependencies; imported by every module of the block.
package gsi_pkg;

   localparam int FIELD_BITS    = 32;  // width of count fields and total registers
   localparam int IMP_BITS      = 16;  // width of the impurity result
   localparam int CSR_DATA_BITS = 32;
   localparam int CSR_ADDR_BITS = 3;

   // register select, taken from paddr bit 2
   localparam logic REG_TOTAL_A = 1'b0;
   localparam logic REG_TOTAL_B = 1'b1;

   // sideband that travels with every transaction down the pipeline
   typedef struct packed {
      logic undef;
      logic last;
   } gsi_tag_type;

endpackage

// File: hw/rtl/gsi_front.sv
// gsi_front: range checks, side counts and the multiplier stages that build
// numerator and denominator of the impurity ratio. Depends on gsi_pkg.
module gsi_front import gsi_pkg::*; #(
   parameter int COUNT_BITS = 32,
   localparam int W  = COUNT_BITS + 1,
   localparam int RW = 3 * W + 2
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  en,
   input  logic                  in_valid,
   input  logic [FIELD_BITS-1:0] la_raw,
   input  logic [FIELD_BITS-1:0] lb_raw,
   input  logic                  is_last,
   input  logic [FIELD_BITS-1:0] ta_raw,
   input  logic [FIELD_BITS-1:0] tb_raw,
   output logic                  out_valid,
   output logic [RW-1:0]         out_num,
   output logic [RW-1:0]         out_den,
   output gsi_tag_type           out_tag
);

   localparam int C = COUNT_BITS;

   // stage 1: side counts
   logic [C-1:0] la, lb, ta, tb;
   logic [C-1:0] la_ff, lb_ff, ra_ff, rb_ff, ra_in, rb_in;
   logic [W-1:0] nl_ff, nr_ff, n_ff, nl_in, nr_in, n_in;
   gsi_tag_type  tag1_ff, tag1_in;
   logic         v1_ff;

   assign la = la_raw[C-1:0];
   assign lb = lb_raw[C-1:0];
   assign ta = ta_raw[C-1:0];
   assign tb = tb_raw[C-1:0];

   always_comb begin
      ra_in = ta - la;
      rb_in = tb - lb;
      nl_in = W'(la) + W'(lb);
      nr_in = W'(ra_in) + W'(rb_in);
      n_in  = W'(ta) + W'(tb);
      tag1_in.undef = (la > ta) || (lb > tb);
      tag1_in.last  = is_last;
   end

   // stage 2: pair products, empty-side check
   logic [2*W-1:0] pab_ff, prr_ff, pnn_ff;
   logic [W-1:0]   nl2_ff, nr2_ff, n2_ff;
   gsi_tag_type    tag2_ff, tag2_in;
   logic           v2_ff;

   always_comb begin
      tag2_in       = tag1_ff;
      tag2_in.undef = tag1_ff.undef || (nl_ff == '0) || (nr_ff == '0);
   end

   // stage 3: partial products against the third factor, split in halves
   logic [2*W-1:0] a_lo_ff, a_hi_ff, b_lo_ff, b_hi_ff, c_lo_ff, c_hi_ff;
   gsi_tag_type    tag3_ff;
   logic           v3_ff;

   // stage 4: recombine
   logic [RW-1:0] num_ff, den_ff, num_in, den_in;
   gsi_tag_type   tag4_ff;
   logic          v4_ff;

   always_comb begin
      num_in = RW'(a_lo_ff) + (RW'(a_hi_ff) << W) + RW'(b_lo_ff) + (RW'(b_hi_ff) << W);
      den_in = RW'(c_lo_ff) + (RW'(c_hi_ff) << W);
   end

   always_ff @(posedge clock) begin
      if (en) begin
         la_ff   <= la;
         lb_ff   <= lb;
         ra_ff   <= ra_in;
         rb_ff   <= rb_in;
         nl_ff   <= nl_in;
         nr_ff   <= nr_in;
         n_ff    <= n_in;
         tag1_ff <= tag1_in;

         pab_ff  <= (2*W)'(la_ff) * (2*W)'(lb_ff);
         prr_ff  <= (2*W)'(ra_ff) * (2*W)'(rb_ff);
         pnn_ff  <= (2*W)'(nl_ff) * (2*W)'(nr_ff);
         nl2_ff  <= nl_ff;
         nr2_ff  <= nr_ff;
         n2_ff   <= n_ff;
         tag2_ff <= tag2_in;

         a_lo_ff <= (2*W)'(pab_ff[W-1:0])   * (2*W)'(nr2_ff);
         a_hi_ff <= (2*W)'(pab_ff[2*W-1:W]) * (2*W)'(nr2_ff);
         b_lo_ff <= (2*W)'(prr_ff[W-1:0])   * (2*W)'(nl2_ff);
         b_hi_ff <= (2*W)'(prr_ff[2*W-1:W]) * (2*W)'(nl2_ff);
         c_lo_ff <= (2*W)'(pnn_ff[W-1:0])   * (2*W)'(n2_ff);
         c_hi_ff <= (2*W)'(pnn_ff[2*W-1:W]) * (2*W)'(n2_ff);
         tag3_ff <= tag2_ff;

         num_ff  <= num_in;
         den_ff  <= den_in;
         tag4_ff <= tag3_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
      end else if (en) begin
         v1_ff <= in_valid;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
         v4_ff <= v3_ff;
      end
   end

   assign out_valid = v4_ff;
   assign out_num   = num_ff;
   assign out_den   = den_ff;
   assign out_tag   = tag4_ff;

endmodule

// File: hw/rtl/gsi_div_step.sv
// gsi_div_step: one registered step of restoring division, one quotient bit.
// Depends on gsi_pkg.
module gsi_div_step import gsi_pkg::*; #(
   parameter int RW = 101,
   parameter int QW = 17
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          en,
   input  logic          in_valid,
   input  logic [RW-1:0] in_rem,
   input  logic [RW-1:0] in_den,
   input  logic [QW-1:0] in_quo,
   input  gsi_tag_type   in_tag,
   output logic          out_valid,
   output logic [RW-1:0] out_rem,
   output logic [RW-1:0] out_den,
   output logic [QW-1:0] out_quo,
   output gsi_tag_type   out_tag
);

   logic [RW-1:0] shifted, rem_ff, rem_in, den_ff;
   logic [QW-1:0] quo_ff, quo_in;
   gsi_tag_type   tag_ff;
   logic          valid_ff, ge;

   always_comb begin
      shifted = {in_rem[RW-2:0], 1'b0};
      ge      = (shifted >= in_den);
      rem_in  = ge ? (shifted - in_den) : shifted;
      quo_in  = {in_quo[QW-2:0], ge};
   end

   always_ff @(posedge clock) begin
      if (en) begin
         rem_ff <= rem_in;
         den_ff <= in_den;
         quo_ff <= quo_in;
         tag_ff <= in_tag;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (en) begin
         valid_ff <= in_valid;
      end
   end

   assign out_valid = valid_ff;
   assign out_rem   = rem_ff;
   assign out_den   = den_ff;
   assign out_quo   = quo_ff;
   assign out_tag   = tag_ff;

endmodule

// File: hw/rtl/weighted_gini_split_impurity.sv
// weighted_gini_split_impurity: top level, CSR block, pipeline assembly, output stage.
// Depends on gsi_pkg, gsi_front and gsi_div_step.
//
//   channel   direction  handshake            payload
//   req_      in         req_valid/req_ready  left_count_a, left_count_b, is_last
//   rsp_      out        rsp_valid/rsp_ready  impurity, undefined_split, last_out
//   csr_      in         APB, pready tied 1   total_count_a @0x0, total_count_b @0x4
//
// One transaction per cycle sustained while the output is not stalled. The pipeline
// has four front stages (side counts, two multiplier stages, recombine),
// FRAC_BITS + 1 division steps of one quotient bit each, and the output register.
// Synchronous reset clears all valid bits and both totals.
// The whole pipeline advances together; it holds only while a result sits in
// the output register and rsp_ready is low, so nothing is dropped or repeated.
module weighted_gini_split_impurity import gsi_pkg::*; #(
   parameter int COUNT_BITS = 32,
   parameter int FRAC_BITS  = 16
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_ready,
   input  logic [FIELD_BITS-1:0]    req_left_count_a,
   input  logic [FIELD_BITS-1:0]    req_left_count_b,
   input  logic                     req_is_last,
   output logic                     rsp_valid,
   input  logic                     rsp_ready,
   output logic [IMP_BITS-1:0]      rsp_impurity,
   output logic                     rsp_undefined_split,
   output logic                     rsp_last_out,
   input  logic                     csr_psel,
   input  logic                     csr_penable,
   input  logic                     csr_pwrite,
   input  logic [CSR_ADDR_BITS-1:0] csr_paddr,
   input  logic [CSR_DATA_BITS-1:0] csr_pwdata,
   output logic [CSR_DATA_BITS-1:0] csr_prdata,
   output logic                     csr_pready
);

   localparam int W  = COUNT_BITS + 1;
   localparam int RW = 3 * W + 2;
   localparam int QW = FRAC_BITS + 1;

   // configuration registers
   logic [FIELD_BITS-1:0] total_a_ff, total_b_ff;
   logic                  csr_wr;

   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite;

   always_ff @(posedge clock) begin
      if (reset) begin
         total_a_ff <= '0;
         total_b_ff <= '0;
      end else if (csr_wr) begin
         unique case (csr_paddr[2])
            REG_TOTAL_A: total_a_ff <= csr_pwdata;
            REG_TOTAL_B: total_b_ff <= csr_pwdata;
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (csr_paddr[2])
         REG_TOTAL_A: csr_prdata = total_a_ff;
         REG_TOTAL_B: csr_prdata = total_b_ff;
         default:     csr_prdata = '0;
      endcase
   end

   // advance everything unless the output register holds an untaken result
   logic en;
   logic rsp_valid_ff;

   assign en        = !rsp_valid_ff || rsp_ready;
   assign req_ready = en;

   // front: numerator and denominator
   logic [RW-1:0] rem_pipe [0:QW];
   logic [RW-1:0] den_pipe [0:QW];
   logic [QW-1:0] quo_pipe [0:QW];
   gsi_tag_type   tag_pipe [0:QW];
   logic          vld_pipe [0:QW];

   gsi_front #(
      .COUNT_BITS(COUNT_BITS)
   ) u_front (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (req_valid),
      .la_raw    (req_left_count_a),
      .lb_raw    (req_left_count_b),
      .is_last   (req_is_last),
      .ta_raw    (total_a_ff),
      .tb_raw    (total_b_ff),
      .out_valid (vld_pipe[0]),
      .out_num   (rem_pipe[0]),
      .out_den   (den_pipe[0]),
      .out_tag   (tag_pipe[0])
   );

   assign quo_pipe[0] = '0;

   // division: one quotient bit per stage
   for (genvar k = 0; k < QW; k++) begin : g_div
      gsi_div_step #(
         .RW(RW),
         .QW(QW)
      ) u_step (
         .clock     (clock),
         .reset     (reset),
         .en        (en),
         .in_valid  (vld_pipe[k]),
         .in_rem    (rem_pipe[k]),
         .in_den    (den_pipe[k]),
         .in_quo    (quo_pipe[k]),
         .in_tag    (tag_pipe[k]),
         .out_valid (vld_pipe[k+1]),
         .out_rem   (rem_pipe[k+1]),
         .out_den   (den_pipe[k+1]),
         .out_quo   (quo_pipe[k+1]),
         .out_tag   (tag_pipe[k+1])
      );
   end

   // output stage: saturate, force zero for undefined splits
   logic [IMP_BITS-1:0] imp_ff, imp_in;
   logic                undef_ff, last_ff, sat;

   always_comb begin
      sat = |(quo_pipe[QW] >> IMP_BITS);
      if (tag_pipe[QW].undef) begin
         imp_in = '0;
      end else if (sat) begin
         imp_in = '1;
      end else begin
         imp_in = IMP_BITS'(quo_pipe[QW]);
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         imp_ff   <= imp_in;
         undef_ff <= tag_pipe[QW].undef;
         last_ff  <= tag_pipe[QW].last;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (en) begin
         rsp_valid_ff <= vld_pipe[QW];
      end
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_impurity        = imp_ff;
   assign rsp_undefined_split = undef_ff;
   assign rsp_last_out        = last_ff;

endmodule

// File: hw/rtl/gsi_checker.sv
// gsi_checker: port-level assertions for the impurity block, bound to the top level.
// Depends on gsi_pkg and weighted_gini_split_impurity.
module gsi_checker import gsi_pkg::*; (
   input logic                clock,
   input logic                reset,
   input logic                req_ready,
   input logic                rsp_valid,
   input logic                rsp_ready,
   input logic [IMP_BITS-1:0] rsp_impurity,
   input logic                rsp_undefined_split,
   input logic                rsp_last_out
);

   a_reset_clears: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result valid right after reset");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_impurity)
         && $stable(rsp_undefined_split) && $stable(rsp_last_out))
      else $error("stalled result changed");

   a_undef_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_undefined_split |-> rsp_impurity == '0)
      else $error("undefined split with nonzero impurity");

   a_ready_follows: assert property (@(posedge clock) disable iff (reset)
      req_ready == (!rsp_valid || rsp_ready))
      else $error("input ready does not follow output stall");

endmodule

bind weighted_gini_split_impurity gsi_checker u_gsi_checker (.*);

// File: bench/gini_split_checker.sv
// gini_split_checker: watches the request, response and CSR ports of the Gini split block,
// predicts each impurity result and compares it in order. Depends on gsi_pkg.
module gini_split_checker import gsi_pkg::*; #(
   parameter int FRAC_BITS = 16
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   input  logic                     req_ready,
   input  logic [FIELD_BITS-1:0]    req_left_count_a,
   input  logic [FIELD_BITS-1:0]    req_left_count_b,
   input  logic                     req_is_last,
   input  logic                     rsp_valid,
   input  logic                     rsp_ready,
   input  logic [IMP_BITS-1:0]      rsp_impurity,
   input  logic                     rsp_undefined_split,
   input  logic                     rsp_last_out,
   input  logic                     csr_psel,
   input  logic                     csr_penable,
   input  logic                     csr_pwrite,
   input  logic                     csr_pready,
   input  logic [CSR_ADDR_BITS-1:0] csr_paddr,
   input  logic [CSR_DATA_BITS-1:0] csr_pwdata,
   output int                       failures,
   output int                       pending
);
   timeunit 1ns;
   timeprecision 1ps;

   typedef struct packed {
      logic [IMP_BITS-1:0] impurity;
      logic                undef;
      logic                last;
   } split_score_type;

   logic [FIELD_BITS-1:0] node_total_a, node_total_b;
   split_score_type       scores_due[$];

   function automatic split_score_type score_split(logic [FIELD_BITS-1:0] ta,
                                                   logic [FIELD_BITS-1:0] tb,
                                                   logic [FIELD_BITS-1:0] la,
                                                   logic [FIELD_BITS-1:0] lb,
                                                   logic last);
      split_score_type s;
      logic [FIELD_BITS-1:0] ra, rb;
      logic [FIELD_BITS:0]   nl, nr, n;
      logic [127:0]          num, den, quo;
      s = '{impurity: '0, undef: 1'b1, last: last};
      if (la > ta || lb > tb) return s;
      ra = ta - la;
      rb = tb - lb;
      nl = {1'b0, la} + {1'b0, lb};
      nr = {1'b0, ra} + {1'b0, rb};
      n  = {1'b0, ta} + {1'b0, tb};
      if (nl == 0 || nr == 0) return s;
      num = 128'(la) * 128'(lb) * 128'(nr) + 128'(ra) * 128'(rb) * 128'(nl);
      den = 128'(nl) * 128'(nr) * 128'(n);
      // quotient carries one extra bit: the factor of two in 2*num/den
      quo = (num << (FRAC_BITS + 1)) / den;
      s.undef = 1'b0;
      s.impurity = (quo > 128'hFFFF) ? 16'hFFFF : quo[IMP_BITS-1:0];
      return s;
   endfunction

   task automatic report_mismatch(string what, longint got, longint want);
      $display("mismatch %0s at %0t: got %0h, want %0h", what, $realtime, got, want);
      failures++;
   endtask

   assign pending = scores_due.size();

   initial failures = 0;

   always @(posedge clock) begin
      if (reset) begin
         node_total_a <= '0;
         node_total_b <= '0;
      end else begin
         if (csr_psel && csr_penable && csr_pwrite && csr_pready) begin
            if (csr_paddr[2] == REG_TOTAL_A) node_total_a <= csr_pwdata;
            else node_total_b <= csr_pwdata;
         end
         if (req_valid && req_ready)
            scores_due.push_back(score_split(node_total_a, node_total_b, req_left_count_a,
                                             req_left_count_b, req_is_last));
         if (rsp_valid && rsp_ready) begin
            if (scores_due.size() == 0) begin
               report_mismatch("unexpected result", rsp_impurity, 0);
            end else begin
               split_score_type w;
               w = scores_due.pop_front();
               if (rsp_impurity !== w.impurity)
                  report_mismatch("impurity", rsp_impurity, w.impurity);
               if (rsp_undefined_split !== w.undef)
                  report_mismatch("undefined_split", rsp_undefined_split, w.undef);
               if (rsp_last_out !== w.last)
                  report_mismatch("last_out", rsp_last_out, w.last);
            end
         end
      end
   end
endmodule

// File: bench/testbench.sv
// testbench: drives the weighted Gini split block with directed and random splits,
// totals set over the CSR port. Depends on gsi_pkg and gini_split_checker.
module testbench;
   import gsi_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   localparam logic [FIELD_BITS-1:0] COUNT_MAX = '1;
   localparam int LATENCY_CYCLES = 16 + 6;   // front stages, division steps and output register at the default setting
   localparam int IDLE_LIMIT     = 5000;     // cycles with no transaction before giving up

   logic                     clock = 1'b0;
   logic                     reset = 1'b1;
   logic                     req_valid = 1'b0;
   logic                     req_ready;
   logic [FIELD_BITS-1:0]    req_left_count_a = '0;
   logic [FIELD_BITS-1:0]    req_left_count_b = '0;
   logic                     req_is_last = 1'b0;
   logic                     rsp_valid;
   logic                     rsp_ready = 1'b0;
   logic [IMP_BITS-1:0]      rsp_impurity;
   logic                     rsp_undefined_split;
   logic                     rsp_last_out;
   logic                     csr_psel = 1'b0;
   logic                     csr_penable = 1'b0;
   logic                     csr_pwrite = 1'b0;
   logic [CSR_ADDR_BITS-1:0] csr_paddr = '0;
   logic [CSR_DATA_BITS-1:0] csr_pwdata = '0;
   logic [CSR_DATA_BITS-1:0] csr_prdata;
   logic                     csr_pready;

   int failures, pending;
   int idle_cycles = 0;
   bit long_hold = 1'b0;   // set by the stimulus to make the receiver back off for a long stretch
   logic [FIELD_BITS-1:0] tot_a, tot_b;

   always #10 clock = ~clock;

   weighted_gini_split_impurity dut (.*);

   gini_split_checker #(.FRAC_BITS(16)) scoreboard (.*);

   // Watchdog: abort if no transaction on any port for too long.
   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready) || (csr_psel && csr_penable))
         idle_cycles <= 0;
      else if (idle_cycles >= IDLE_LIMIT) begin
         $display("simulation failed");
         $finish;
      end else
         idle_cycles <= idle_cycles + 1;
   end

   // Receiver: mostly ready, short random stalls, rare long ones, and one long
   // hold-off on request so the pipeline fills and pushes back on the sender.
   initial begin : receiver
      int stall;
      stall = 0;
      @(negedge reset);
      forever begin
         @(posedge clock);
         if (long_hold && stall == 0) begin
            stall = 300;
            long_hold = 1'b0;
         end
         if (stall > 0) begin
            rsp_ready <= 1'b0;
            stall--;
         end else begin
            case ($urandom_range(0, 19))
               0, 1, 2, 3: stall = $urandom_range(1, 3);
               4:          stall = $urandom_range(15, 60);
               default:    stall = 0;
            endcase
            rsp_ready <= (stall == 0);
         end
      end
   end

   // Write one total register: setup phase, then access phase.
   task automatic write_total(logic sel, logic [CSR_DATA_BITS-1:0] value);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= {sel, 2'b00};
      csr_pwdata  <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
   endtask

   // Drain the pipeline, then load new node totals while the block is idle.
   task automatic load_totals(logic [FIELD_BITS-1:0] a, logic [FIELD_BITS-1:0] b);
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (LATENCY_CYCLES) @(posedge clock);
      write_total(REG_TOTAL_A, a);
      write_total(REG_TOTAL_B, b);
      tot_a = a;
      tot_b = b;
   endtask

   // Offer one split and hold it until accepted; optionally drop valid for a gap.
   task automatic send_split(logic [FIELD_BITS-1:0] la, logic [FIELD_BITS-1:0] lb, logic last);
      int gap;
      req_valid        <= 1'b1;
      req_left_count_a <= la;
      req_left_count_b <= lb;
      req_is_last      <= last;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      case ($urandom_range(0, 9))
         0, 1, 2: gap = $urandom_range(1, 3);
         3:       gap = ($urandom_range(0, 3) == 0) ? $urandom_range(10, 40) : 0;
         default: gap = 0;
      endcase
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   // Left count for a random split: mostly inside the total, some at the edges,
   // some anywhere in the field to hit the over-total case.
   function automatic logic [FIELD_BITS-1:0] pick_left(logic [FIELD_BITS-1:0] total);
      case ($urandom_range(0, 19))
         0, 1:    return $urandom();
         2:       return total;
         3:       return '0;
         4:       return total + 1;
         default: return $urandom_range(0, total);
      endcase
   endfunction

   initial begin : stimulus
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Empty node: every split is undefined.
      send_split(0, 0, 1'b0);
      send_split(1, 0, 1'b1);
      load_totals(10, 6);
      send_split(0, 0, 1'b0);    // empty left side
      send_split(10, 6, 1'b0);   // empty right side
      send_split(11, 0, 1'b0);   // class A over total
      send_split(0, 7, 1'b0);    // class B over total
      send_split(5, 3, 1'b0);
      send_split(10, 0, 1'b0);
      send_split(0, 6, 1'b0);
      send_split(3, 5, 1'b1);
      load_totals(COUNT_MAX, COUNT_MAX);
      send_split(COUNT_MAX, COUNT_MAX, 1'b0);
      send_split(COUNT_MAX, 0, 1'b0);
      send_split(0, COUNT_MAX, 1'b0);
      send_split(1, 1, 1'b0);
      send_split(COUNT_MAX - 1, COUNT_MAX, 1'b0);
      send_split(32'h8000_0000, 32'h1234_5678, 1'b1);
      load_totals(1, 0);
      send_split(1, 0, 1'b0);
      send_split(0, 0, 1'b0);
      load_totals(1, 1);
      send_split(1, 0, 1'b0);
      send_split(0, 1, 1'b1);

      // Random phases, each with its own node totals.
      for (int phase = 0; phase < 8; phase++) begin
         case (phase)
            0:       load_totals(COUNT_MAX, COUNT_MAX);
            1:       load_totals(0, $urandom_range(1, 50));
            2, 5:    load_totals($urandom_range(1, 20), $urandom_range(1, 20));
            3:       load_totals($urandom_range(0, 3), $urandom_range(0, 3));
            default: load_totals($urandom(), $urandom());
         endcase
         if (phase == 4) long_hold = 1'b1;
         repeat (125) send_split(pick_left(tot_a), pick_left(tot_b), $urandom_range(0, 7) == 0);
      end

      req_valid <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (LATENCY_CYCLES + 10) @(posedge clock);
      if (failures == 0)
         $display("simulation ok");
      else
         $display("simulation failed");
      $finish;
   end
endmodule

// File: filelist.f
hw/rtl/gsi_pkg.sv
hw/rtl/gsi_front.sv
hw/rtl/gsi_div_step.sv
hw/rtl/weighted_gini_split_impurity.sv
hw/rtl/gsi_checker.sv
bench/gini_split_checker.sv
bench/testbench.sv
